// ===== rtl/core/nnis_pkg.sv =====
// shared types, widths and codes for the nearest-neighbor image scaler
`timescale 1ns / 1ps

package nnis_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_DIM     = 256;
    localparam int DEF_STORE_DEPTH = 65536;

    // field widths
    localparam int POS_W      = 11;
    localparam int COORD_W    = POS_W - 1;   // a nonnegative coordinate
    localparam int SRC_DIM_W  = 9;
    localparam int DST_DIM_W  = 11;
    localparam int PIX_W      = 8;
    localparam int IN_TDATA_W = 32;

    // a source index always lies below the source dimension (at most 511)
    localparam int QUO_W       = SRC_DIM_W;
    // coordinate times source dimension
    localparam int PROD_W      = COORD_W + SRC_DIM_W + 1;
    // column plus width times row stays below 511 * 511
    localparam int ADDR_FULL_W = 18;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [SRC_DIM_W-1:0] RST_SRC_DIM = 9'd256;
    localparam logic [DST_DIM_W-1:0] RST_DST_DIM = 11'd256;

    // input commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // item kinds after classification
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ_IN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_NIL = 2'd2;  // inside, empty source
    localparam logic [KIND_W-1:0] KIND_READ_OUT = 2'd3;

    // queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [SRC_DIM_W-1:0] src_w;   // already clamped to the maximum
        logic [SRC_DIM_W-1:0] src_h;
        logic [DST_DIM_W-1:0] dst_w;
        logic [DST_DIM_W-1:0] dst_h;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   value;
    } item_t;

endpackage

// ===== rtl/core/nearest_neighbor_image_scaler.sv =====
// top level of the nearest-neighbor image scaler
`timescale 1ns / 1ps

// Frame store of 8-bit pixels with nearest-neighbor scaled readout. A write word
// stores one source pixel at (x, y), row by row with the source width as stride;
// writes off the source are dropped. A read word names a destination pixel and
// returns the source pixel at (x*src_w/dst_w, y*src_h/dst_h), or 0 with in_range
// low when it lies off the destination. Words are sorted on entry and held in a
// two-entry queue; the execution side takes one at a time. An in-range read is
// dominated by the 9-step shift-subtract divider that forms column and row
// together; all other words skip it. The store is a single-port memory of
// STORE_DEPTH bytes, not cleared at reset; reading a pixel never written gives an
// arbitrary value. Source sizes above MAX_DIM are clamped. The user must write
// configuration only while idle; the block does not enforce it.

module nearest_neighbor_image_scaler #(
    parameter int MAX_DIM     = nnis_pkg::DEF_MAX_DIM,
    parameter int STORE_DEPTH = nnis_pkg::DEF_STORE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_pos[10:0], y_pos[21:11], write_value[29:22], zero pad[31:30]
    input  logic [nnis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_value[7:0]
    output logic [nnis_pkg::PIX_W-1:0]          m_axis_tdata,
    // in_range
    output logic                                m_axis_tuser,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [nnis_pkg::SRC_DIM_W-1:0] src_w_reg;
    logic [nnis_pkg::SRC_DIM_W-1:0] src_h_reg;
    logic [nnis_pkg::DST_DIM_W-1:0] dst_w_reg;
    logic [nnis_pkg::DST_DIM_W-1:0] dst_h_reg;
    nnis_pkg::cfg_t                 cfg;
    logic                           q_full;
    logic                           q_push;
    nnis_pkg::item_t                q_item;
    logic                           q_valid;
    logic                           q_pop;
    nnis_pkg::item_t                q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= nnis_pkg::RST_SRC_DIM;
            src_h_reg <= nnis_pkg::RST_SRC_DIM;
            dst_w_reg <= nnis_pkg::RST_DST_DIM;
            dst_h_reg <= nnis_pkg::RST_DST_DIM;
        end else if (cfg_valid) begin
            case (cfg_index)
                nnis_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_data[nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_data[nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                nnis_pkg::REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp source size to the largest supported dimension
    assign cfg.src_w = (32'(src_w_reg) > 32'(MAX_DIM))
                       ? nnis_pkg::SRC_DIM_W'(MAX_DIM) : src_w_reg;
    assign cfg.src_h = (32'(src_h_reg) > 32'(MAX_DIM))
                       ? nnis_pkg::SRC_DIM_W'(MAX_DIM) : src_h_reg;
    assign cfg.dst_w = dst_w_reg;
    assign cfg.dst_h = dst_h_reg;

    nnis_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    nnis_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    nnis_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/nnis_front.sv =====
// input side: takes words, sorts them into kinds and drops dead writes
`timescale 1ns / 1ps

module nnis_front (
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [nnis_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tuser,
    input  nnis_pkg::cfg_t                       cfg,
    input  logic                                 q_full,
    output logic                                 q_push,
    output nnis_pkg::item_t                      q_item
);

    logic [nnis_pkg::POS_W-1:0] x_pos;
    logic [nnis_pkg::POS_W-1:0] y_pos;
    logic [nnis_pkg::PIX_W-1:0] write_value;
    logic                       nonneg;
    logic                       in_src;
    logic                       in_dst;
    logic                       keep;

    assign x_pos       = s_axis_tdata[10:0];
    assign y_pos       = s_axis_tdata[21:11];
    assign write_value = s_axis_tdata[29:22];

    assign nonneg = !x_pos[nnis_pkg::POS_W-1] && !y_pos[nnis_pkg::POS_W-1];

    assign in_src = nonneg
        && (x_pos[nnis_pkg::COORD_W-1:0] < nnis_pkg::COORD_W'(cfg.src_w))
        && (y_pos[nnis_pkg::COORD_W-1:0] < nnis_pkg::COORD_W'(cfg.src_h));

    assign in_dst = nonneg
        && (nnis_pkg::DST_DIM_W'(x_pos[nnis_pkg::COORD_W-1:0]) < cfg.dst_w)
        && (nnis_pkg::DST_DIM_W'(y_pos[nnis_pkg::COORD_W-1:0]) < cfg.dst_h);

    always_comb begin
        q_item.x     = x_pos[nnis_pkg::COORD_W-1:0];
        q_item.y     = y_pos[nnis_pkg::COORD_W-1:0];
        q_item.value = write_value;
        keep         = 1'b1;
        if (s_axis_tuser == nnis_pkg::CMD_WRITE) begin
            q_item.kind = nnis_pkg::KIND_WRITE;
            keep        = in_src;
        end else if (!in_dst) begin
            q_item.kind = nnis_pkg::KIND_READ_OUT;
        end else if (cfg.src_w == '0 || cfg.src_h == '0) begin
            q_item.kind = nnis_pkg::KIND_READ_NIL;
        end else begin
            q_item.kind = nnis_pkg::KIND_READ_IN;
        end
    end

    // writes outside the source are taken and dropped here
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

// ===== rtl/core/nnis_queue.sv =====
// short fifo of classified items between front and back
`timescale 1ns / 1ps

module nnis_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  nnis_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output nnis_pkg::item_t head
);

    localparam int PTR_W = (nnis_pkg::Q_DEPTH > 1) ? $clog2(nnis_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(nnis_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(nnis_pkg::Q_DEPTH - 1);

    nnis_pkg::item_t  slot_reg [nnis_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(nnis_pkg::Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/nnis_back.sv =====
// execution side: scaling divide, frame store access and result register
`timescale 1ns / 1ps

module nnis_back #(
    parameter int STORE_DEPTH = nnis_pkg::DEF_STORE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  nnis_pkg::cfg_t                   cfg,
    input  logic                             q_valid,
    input  nnis_pkg::item_t                  q_head,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [nnis_pkg::PIX_W-1:0]       m_axis_tdata,
    output logic                             m_axis_tuser
);

    localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int STEP_W = $clog2(nnis_pkg::QUO_W);
    localparam int AF_W   = nnis_pkg::ADDR_FULL_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_MEM  = 3'd4;
    localparam logic [2:0] ST_RESP = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [nnis_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [nnis_pkg::COORD_W-1:0]      x_reg, x_next;
    logic [nnis_pkg::COORD_W-1:0]      y_reg, y_next;
    logic [nnis_pkg::PIX_W-1:0]        val_reg, val_next;
    logic [nnis_pkg::PROD_W-1:0]       rem_x_reg, rem_x_next;
    logic [nnis_pkg::PROD_W-1:0]       rem_y_reg, rem_y_next;
    logic [nnis_pkg::QUO_W-1:0]        quo_x_reg, quo_x_next;
    logic [nnis_pkg::QUO_W-1:0]        quo_y_reg, quo_y_next;
    logic [STEP_W-1:0]                 step_reg, step_next;
    logic [AF_W-1:0]                   addr_reg, addr_next;
    logic                              use_mem_reg, use_mem_next;
    logic                              flag_reg, flag_next;
    logic                              out_valid_reg, out_valid_next;
    logic [nnis_pkg::PIX_W-1:0]        out_data_reg, out_data_next;
    logic                              out_flag_reg, out_flag_next;
    logic [nnis_pkg::PIX_W-1:0]        rd_data_reg;

    logic [nnis_pkg::PROD_W-1:0]       div_x;
    logic [nnis_pkg::PROD_W-1:0]       div_y;
    logic                              take_x;
    logic                              take_y;
    logic [AF_W:0]                     wr_prod;
    logic [AF_W:0]                     rd_prod;
    logic                              addr_ok;
    logic                              mem_wr;
    logic                              mem_rd;
    logic [AW-1:0]                     mem_idx;

    logic [nnis_pkg::PIX_W-1:0]        frame_mem [STORE_DEPTH];

    // one quotient bit per cycle for column and row side by side
    assign div_x  = nnis_pkg::PROD_W'(cfg.dst_w) << step_reg;
    assign div_y  = nnis_pkg::PROD_W'(cfg.dst_h) << step_reg;
    assign take_x = (rem_x_reg >= div_x);
    assign take_y = (rem_y_reg >= div_y);

    assign wr_prod = (AF_W + 1)'(cfg.src_w) * (AF_W + 1)'(y_reg);
    assign rd_prod = (AF_W + 1)'(cfg.src_w) * (AF_W + 1)'(quo_y_reg);

    assign addr_ok = (32'(addr_reg) < 32'(STORE_DEPTH));
    assign mem_idx = AW'(addr_reg);
    assign mem_wr  = (state_reg == ST_MEM) && (kind_reg == nnis_pkg::KIND_WRITE) && addr_ok;
    assign mem_rd  = (state_reg == ST_MEM) && (kind_reg != nnis_pkg::KIND_WRITE) && addr_ok;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        val_next       = val_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        quo_x_next     = quo_x_reg;
        quo_y_next     = quo_y_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        use_mem_next   = use_mem_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    kind_next    = q_head.kind;
                    x_next       = q_head.x;
                    y_next       = q_head.y;
                    val_next     = q_head.value;
                    use_mem_next = 1'b0;
                    case (q_head.kind)
                        nnis_pkg::KIND_WRITE,
                        nnis_pkg::KIND_READ_IN: begin
                            state_next = ST_MUL;
                        end
                        nnis_pkg::KIND_READ_NIL: begin
                            flag_next  = 1'b1;
                            state_next = ST_RESP;
                        end
                        default: begin
                            flag_next  = 1'b0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (kind_reg == nnis_pkg::KIND_WRITE) begin
                    addr_next  = AF_W'(x_reg) + AF_W'(wr_prod);
                    state_next = ST_MEM;
                end else begin
                    rem_x_next = nnis_pkg::PROD_W'(x_reg) * nnis_pkg::PROD_W'(cfg.src_w);
                    rem_y_next = nnis_pkg::PROD_W'(y_reg) * nnis_pkg::PROD_W'(cfg.src_h);
                    quo_x_next = '0;
                    quo_y_next = '0;
                    step_next  = STEP_W'(nnis_pkg::QUO_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (take_x) begin
                    rem_x_next = rem_x_reg - div_x;
                end
                if (take_y) begin
                    rem_y_next = rem_y_reg - div_y;
                end
                quo_x_next = {quo_x_reg[nnis_pkg::QUO_W-2:0], take_x};
                quo_y_next = {quo_y_reg[nnis_pkg::QUO_W-2:0], take_y};
                if (step_reg == '0) begin
                    state_next = ST_ADDR;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ADDR: begin
                addr_next  = AF_W'(quo_x_reg) + AF_W'(rd_prod);
                state_next = ST_MEM;
            end
            ST_MEM: begin
                if (kind_reg == nnis_pkg::KIND_WRITE) begin
                    state_next = ST_IDLE;
                end else begin
                    use_mem_next = addr_ok;
                    flag_next    = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = use_mem_reg ? rd_data_reg : '0;
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        val_reg      <= val_next;
        rem_x_reg    <= rem_x_next;
        rem_y_reg    <= rem_y_next;
        quo_x_reg    <= quo_x_next;
        quo_y_reg    <= quo_y_next;
        step_reg     <= step_next;
        addr_reg     <= addr_next;
        use_mem_reg  <= use_mem_next;
        flag_reg     <= flag_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    // frame store, one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            frame_mem[mem_idx] <= val_reg;
        end
        if (mem_rd) begin
            rd_data_reg <= frame_mem[mem_idx];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the nearest-neighbor image scaler
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 24;
    localparam int PHASE_WORDS   = 153;
    localparam int NUM_PROBES    = 25;
    localparam int NUM_SETTINGS  = 10;
    localparam int STORE_ENTRIES = nnis_pkg::DEF_STORE_DEPTH;

    typedef struct packed {
        logic [nnis_pkg::PIX_W-1:0] pixel;
        logic                       on_dest;
    } scaled_pixel_t;

    typedef struct {
        logic cmd;
        int   x;
        int   y;
        int   value;
        bit   typed;
        int   pixel;
        bit   on_dest;
    } probe_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [nnis_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [nnis_pkg::PIX_W-1:0]      m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    // scaler state as the testbench sees it
    logic [nnis_pkg::PIX_W-1:0]     image_mem [STORE_ENTRIES];
    bit                             pixel_set [STORE_ENTRIES];
    logic [nnis_pkg::SRC_DIM_W-1:0] src_w_q = nnis_pkg::RST_SRC_DIM;
    logic [nnis_pkg::SRC_DIM_W-1:0] src_h_q = nnis_pkg::RST_SRC_DIM;
    logic [nnis_pkg::DST_DIM_W-1:0] dst_w_q = nnis_pkg::RST_DST_DIM;
    logic [nnis_pkg::DST_DIM_W-1:0] dst_h_q = nnis_pkg::RST_DST_DIM;

    scaled_pixel_t pending_pixels [$];

    int  mismatches    = 0;
    int  pixel_writes  = 0;
    int  reads_on_dest = 0;
    int  reads_off     = 0;
    int  settings_done = 0;
    bit  source_burst  = 1'b0;
    bit  sink_burst    = 1'b0;
    bit  hold_request  = 1'b0;

    // directed words; rows with typed set carry their own expected result
    probe_t probes [NUM_PROBES] = '{
        '{nnis_pkg::CMD_WRITE,     0,     0, 8'h00, 0, 0,     0},
        '{nnis_pkg::CMD_READ,      0,     0, 0,     1, 8'h00, 1},
        '{nnis_pkg::CMD_WRITE,     0,     0, 8'hFF, 0, 0,     0},
        '{nnis_pkg::CMD_READ,      0,     0, 0,     1, 8'hFF, 1},
        '{nnis_pkg::CMD_WRITE,   255,   255, 8'hA5, 0, 0,     0},
        '{nnis_pkg::CMD_READ,    255,   255, 0,     1, 8'hA5, 1},
        '{nnis_pkg::CMD_WRITE,  1023,  1023, 8'h3C, 0, 0,     0},
        '{nnis_pkg::CMD_WRITE, -1024, -1024, 8'hC3, 0, 0,     0},
        '{nnis_pkg::CMD_WRITE,    -1,    -1, 8'hFF, 0, 0,     0},
        '{nnis_pkg::CMD_WRITE,   256,     0, 8'h11, 0, 0,     0},
        '{nnis_pkg::CMD_WRITE,     0,   256, 8'h22, 0, 0,     0},
        '{nnis_pkg::CMD_READ,    255,   255, 0,     1, 8'hA5, 1},
        '{nnis_pkg::CMD_READ,      0,     0, 0,     1, 8'hFF, 1},
        '{nnis_pkg::CMD_READ,     -1,     0, 0,     1, 0,     0},
        '{nnis_pkg::CMD_READ,      0,    -1, 0,     1, 0,     0},
        '{nnis_pkg::CMD_READ,    256,     0, 0,     1, 0,     0},
        '{nnis_pkg::CMD_READ,      0,   256, 0,     1, 0,     0},
        '{nnis_pkg::CMD_READ,   1023,  1023, 0,     1, 0,     0},
        '{nnis_pkg::CMD_READ,  -1024, -1024, 0,     1, 0,     0},
        '{nnis_pkg::CMD_WRITE,    17,    42, 8'h5A, 0, 0,     0},
        '{nnis_pkg::CMD_READ,     17,    42, 0,     1, 8'h5A, 1},
        '{nnis_pkg::CMD_WRITE,   255,     0, 8'h81, 0, 0,     0},
        '{nnis_pkg::CMD_READ,      0,   255, 0,     0, 0,     0},
        '{nnis_pkg::CMD_READ,    255,     0, 0,     1, 8'h81, 1},
        '{nnis_pkg::CMD_READ,    100,   200, 0,     0, 0,     0}
    };

    // src_w, src_h, dst_w, dst_h; the last two rows are replaced by random sizes
    logic [nnis_pkg::CFG_DATA_W-1:0] size_table [NUM_SETTINGS][4] = '{
        '{11'd4,    11'd3,    11'd8,    11'd6},
        '{11'd16,   11'd16,   11'd5,    11'd7},
        '{11'h7FF,  11'h1FF,  11'd2047, 11'd1},
        '{11'd0,    11'd5,    11'd10,   11'd10},
        '{11'd7,    11'd0,    11'd3,    11'd3},
        '{11'd9,    11'd9,    11'd0,    11'd0},
        '{11'd1,    11'd1,    11'd1,    11'd1},
        '{11'd257,  11'd3,    11'd1,    11'd1024},
        '{11'd0,    11'd0,    11'd0,    11'd0},
        '{11'd0,    11'd0,    11'd0,    11'd0}
    };

    logic [nnis_pkg::CFG_IDX_W-1:0] reg_ids [4] = '{
        nnis_pkg::REG_SRC_WIDTH, nnis_pkg::REG_SRC_HEIGHT,
        nnis_pkg::REG_DST_WIDTH, nnis_pkg::REG_DST_HEIGHT};

    nearest_neighbor_image_scaler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned clamp_src(logic [nnis_pkg::SRC_DIM_W-1:0] d);
        return (int'(d) > nnis_pkg::DEF_MAX_DIM) ? nnis_pkg::DEF_MAX_DIM : int'(d);
    endfunction

    // store address a destination pixel maps to, -1 when the store is not read
    function automatic int mapped_addr(int x, int y);
        int sw;
        int sh;
        int col;
        int row;
        sw = clamp_src(src_w_q);
        sh = clamp_src(src_h_q);
        if (x < 0 || y < 0 || x >= int'(dst_w_q) || y >= int'(dst_h_q)) return -1;
        if (sw == 0 || sh == 0) return -1;
        col = (x * sw) / int'(dst_w_q);
        row = (y * sh) / int'(dst_h_q);
        return col + sw * row;
    endfunction

    function automatic int source_gap();
        if ($urandom_range(0, 39) == 0) source_burst = !source_burst;
        return source_burst ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic int sink_gap();
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
        return sink_burst ? 0 : $urandom_range(0, 5);
    endfunction

    // advance the scaler state by one accepted word
    task automatic scale_word(input logic cmd, input logic [nnis_pkg::POS_W-1:0] xp,
                              input logic [nnis_pkg::POS_W-1:0] yp,
                              input logic [nnis_pkg::PIX_W-1:0] v,
                              input bit typed, input scaled_pixel_t typed_px);
        int x;
        int y;
        int sw;
        int sh;
        int addr;
        scaled_pixel_t px;
        x = $signed(xp);
        y = $signed(yp);
        if (cmd == nnis_pkg::CMD_WRITE) begin
            sw = clamp_src(src_w_q);
            sh = clamp_src(src_h_q);
            if (x >= 0 && y >= 0 && x < sw && y < sh) begin
                image_mem[x + sw * y] = v;
                pixel_set[x + sw * y] = 1'b1;
            end
            pixel_writes++;
        end else begin
            addr = mapped_addr(x, y);
            px.on_dest = (x >= 0 && y >= 0 && x < int'(dst_w_q) && y < int'(dst_h_q));
            px.pixel = (addr >= 0) ? image_mem[addr] : '0;
            if (px.on_dest) reads_on_dest++;
            else reads_off++;
            pending_pixels.push_back(typed ? typed_px : px);
        end
    endtask

    task automatic send_word(input logic cmd, input logic [nnis_pkg::POS_W-1:0] xp,
                             input logic [nnis_pkg::POS_W-1:0] yp,
                             input logic [nnis_pkg::PIX_W-1:0] v,
                             input bit typed, input scaled_pixel_t typed_px);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, v, yp, xp};
        do @(negedge aclk); while (!s_axis_tready);
        scale_word(cmd, xp, yp, v, typed, typed_px);
        @(posedge aclk);
    endtask

    // a read whose source pixel was never stored gets that pixel written first
    task automatic read_pixel(input logic [nnis_pkg::POS_W-1:0] xp,
                              input logic [nnis_pkg::POS_W-1:0] yp);
        int addr;
        int sw;
        addr = mapped_addr($signed(xp), $signed(yp));
        sw = clamp_src(src_w_q);
        if (addr >= 0 && !pixel_set[addr])
            send_word(nnis_pkg::CMD_WRITE, nnis_pkg::POS_W'(addr % sw),
                      nnis_pkg::POS_W'(addr / sw), nnis_pkg::PIX_W'($urandom),
                      1'b0, '0);
        send_word(nnis_pkg::CMD_READ, xp, yp, '0, 1'b0, '0);
    endtask

    task automatic set_sizes(input logic [nnis_pkg::CFG_DATA_W-1:0] sizes [4]);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() > 0) @(posedge aclk);
        // writes leave no result, so give the last one time to land
        repeat (DRAIN_CYCLES) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data  <= sizes[i];
            do @(negedge aclk); while (!cfg_ready);
            case (reg_ids[i])
                nnis_pkg::REG_SRC_WIDTH:  src_w_q = sizes[i][nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::REG_SRC_HEIGHT: src_h_q = sizes[i][nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::REG_DST_WIDTH:  dst_w_q = sizes[i];
                default:                  dst_h_q = sizes[i];
            endcase
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // mostly well-formed words, some with coordinates anywhere in the field range
    task automatic run_phase(input int n_words);
        int pick;
        int sw;
        int sh;
        int xmax;
        int ymax;
        logic [nnis_pkg::POS_W-1:0] xp;
        logic [nnis_pkg::POS_W-1:0] yp;
        sw = clamp_src(src_w_q);
        sh = clamp_src(src_h_q);
        xmax = (dst_w_q > 1024) ? 1024 : int'(dst_w_q);
        ymax = (dst_h_q > 1024) ? 1024 : int'(dst_h_q);
        for (int n = 0; n < n_words; n++) begin
            pick = $urandom_range(0, 9);
            xp = nnis_pkg::POS_W'($urandom);
            yp = nnis_pkg::POS_W'($urandom);
            if (pick < 4 && sw > 0 && sh > 0) begin
                send_word(nnis_pkg::CMD_WRITE, nnis_pkg::POS_W'($urandom_range(0, sw - 1)),
                          nnis_pkg::POS_W'($urandom_range(0, sh - 1)),
                          nnis_pkg::PIX_W'($urandom), 1'b0, '0);
            end else if (pick < 8 && xmax > 0 && ymax > 0) begin
                read_pixel(nnis_pkg::POS_W'($urandom_range(0, xmax - 1)),
                           nnis_pkg::POS_W'($urandom_range(0, ymax - 1)));
            end else if (pick % 2 == 0) begin
                send_word(nnis_pkg::CMD_WRITE, xp, yp, nnis_pkg::PIX_W'($urandom),
                          1'b0, '0);
            end else begin
                read_pixel(xp, yp);
            end
        end
    endtask

    // result side
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            gap = sink_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge aclk); while (!m_axis_tvalid);
            @(posedge aclk);
        end
    end

    always @(negedge aclk) begin
        scaled_pixel_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word: pixel %0d in_range %0b", $time,
                         m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata !== want.pixel) begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             want.pixel, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== want.on_dest) begin
                    $display("%0t: in_range expected %0b actual %0b", $time,
                             want.on_dest, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("[nearest_neighbor_image_scaler] ERROR");
        $finish;
    end

    initial begin
        scaled_pixel_t typed_px;
        int waited;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i]) begin
            typed_px.pixel   = nnis_pkg::PIX_W'(probes[i].pixel);
            typed_px.on_dest = probes[i].on_dest;
            if (probes[i].cmd == nnis_pkg::CMD_READ && !probes[i].typed)
                read_pixel(nnis_pkg::POS_W'(probes[i].x), nnis_pkg::POS_W'(probes[i].y));
            else
                send_word(probes[i].cmd, nnis_pkg::POS_W'(probes[i].x),
                          nnis_pkg::POS_W'(probes[i].y),
                          nnis_pkg::PIX_W'(probes[i].value), probes[i].typed, typed_px);
        end

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s >= NUM_SETTINGS - 2) begin
                size_table[s][0] = nnis_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0)
                    ? $urandom_range(0, 511) : $urandom_range(1, 32));
                size_table[s][1] = nnis_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0)
                    ? $urandom_range(0, 511) : $urandom_range(1, 32));
                size_table[s][2] = nnis_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0)
                    ? $urandom_range(0, 2047) : $urandom_range(1, 64));
                size_table[s][3] = nnis_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0)
                    ? $urandom_range(0, 2047) : $urandom_range(1, 64));
            end
            set_sizes(size_table[s]);
            // output stalls for a long stretch while reads keep coming
            if (s == 1) hold_request = 1'b1;
            run_phase(PHASE_WORDS);
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending_pixels.size() > 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        while (pending_pixels.size() > 0) begin
            $display("%0t: missing word: pixel %0d in_range %0b", $time,
                     pending_pixels[0].pixel, pending_pixels[0].on_dest);
            void'(pending_pixels.pop_front());
            mismatches++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d pixel writes and %0d scaled reads (%0d off the destination)",
                 pixel_writes, reads_on_dest + reads_off, reads_off);
        $display("over %0d size settings incl. zero, clamped and oversized dimensions",
                 settings_done);
        if (mismatches == 0) begin
            $display("[nearest_neighbor_image_scaler] OK");
        end else begin
            $display("[nearest_neighbor_image_scaler] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/nnis_pkg.sv
rtl/core/nnis_front.sv
rtl/core/nnis_queue.sv
rtl/core/nnis_back.sv
rtl/core/nearest_neighbor_image_scaler.sv
sim/tb_top.sv
